// ===== hdl/first_fit_pool_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// First-fit pool allocator assertion macros
// Shared assertion forms for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_POOL_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_POOL_ALLOCATOR_MACROS_SVH

// Assert an implication on the rising clock, quiet while reset is held.
`define FFPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert a next-cycle implication on the rising clock.
`define FFPA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ffpa_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit pool allocator package
// Constants, status codes and word types of the allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int unsigned MAX_SEGMENTS_DEF   = 64;
    localparam int unsigned POOL_ADDR_BITS_DEF = 16;

    localparam int unsigned SIZE_W   = 17;
    localparam int unsigned OFFSET_W = 16;
    localparam int unsigned STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADADDR = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic                action;
        logic [SIZE_W-1:0]   request_size;
        logic [OFFSET_W-1:0] block_offset;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFFSET_W-1:0] offset;
    } t_rsp;

endpackage

// ===== hdl/first_fit_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// First-fit pool allocator
// Segment table in one synchronous memory, walked by a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a request word on i_req while busy is low. The word is
//   taken at that edge and busy rises at once. When the work is done,
//   o_done pulses for one cycle with the response word on o_rsp; the
//   receiver must take it then, it cannot hold it off.
//   Write the pool size with i_cfg_we/i_cfg_wdata only while idle; that
//   reinitializes the table to one free segment over the whole pool.
// Operation: the first-fit search and the free lookup read one entry at a
//   time (issue the read, then check the registered data). A split then
//   moves the tail of the table up one entry at a time; a free reads the
//   next and the previous entry, writes the merged entry and moves the
//   tail down by one or two places, again one entry at a time. A zero
//   size alloc or a free offset outside the pool answers without reading
//   the table. Only one request is in flight, so throughput is one word
//   per response.
// Reset: synchronous, active low. The pool is 2^POOL_ADDR_BITS_DEF bytes;
//   busy stays high for the first idle cycle while entry 0 is seeded. No
//   clearing pass is needed, since entries at or above the count are never
//   used.
// ----------------------------------------------------------------------------
`include "first_fit_pool_allocator_macros.svh"

module first_fit_pool_allocator #(
    parameter int unsigned MAX_SEGMENTS   = ffpa_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  ffpa_pkg::t_req           i_req,
    output logic                     o_done,
    output ffpa_pkg::t_rsp           o_rsp,
    input  logic                     i_cfg_we,
    input  logic [ffpa_pkg::SIZE_W-1:0] i_cfg_wdata
);
    import ffpa_pkg::*;

    localparam int unsigned IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
    localparam int unsigned AW = POOL_ADDR_BITS_DEF;
    localparam int unsigned LW = POOL_ADDR_BITS_DEF + 1;
    localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);
    localparam logic [LW-1:0] TOP  = LW'(1) << AW;

    typedef struct packed {
        logic [AW-1:0] start;
        logic [LW-1:0] len;
        logic          free;
    } t_seg;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;  // issue read of entry r_idx
    localparam logic [3:0] S_CHK   = 4'd2;  // data of r_idx valid
    localparam logic [3:0] S_UPRD  = 4'd3;  // shift up: read r_k-1
    localparam logic [3:0] S_UPWR  = 4'd4;  // shift up: write r_k
    localparam logic [3:0] S_DNRD  = 4'd5;  // shift down: read r_k+r_gap
    localparam logic [3:0] S_DNWR  = 4'd6;  // shift down: write r_k
    localparam logic [3:0] S_NXRD  = 4'd7;  // free: read next entry
    localparam logic [3:0] S_NXCK  = 4'd8;
    localparam logic [3:0] S_PVRD  = 4'd9;  // free: read previous entry
    localparam logic [3:0] S_PVCK  = 4'd10;
    localparam logic [3:0] S_SPLIT = 4'd11; // write remainder entry
    localparam logic [3:0] S_DONE  = 4'd12;
    localparam logic [3:0] S_MRG   = 4'd13; // free: write merged entry

    t_seg r_mem [MAX_SEGMENTS];
    t_seg r_rdata;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [LW-1:0] r_pool,  n_pool;
    logic [IW-1:0] r_idx,   n_idx;
    logic [IW-1:0] r_k,     n_k;
    logic [IW-1:0] r_dst,   n_dst;      // entry that takes the merged segment
    logic [1:0]    r_gap,   n_gap;      // entries removed by the merges
    logic          r_act,   n_act;
    logic [LW-1:0] r_size,  n_size;
    logic [AW-1:0] r_off,   n_off;
    t_seg          r_cur,   n_cur;      // segment being updated
    t_seg          r_rest,  n_rest;     // split remainder
    logic [STATUS_W-1:0] r_st, n_st;
    logic [AW-1:0] r_res,   n_res;
    logic          r_done,  n_done;
    logic          r_seed;

    logic          mem_we;
    logic [IW-1:0] mem_wa, mem_ra;
    t_seg          mem_wd;

    logic [LW-1:0] cfg_clamp;
    logic [LW-1:0] seg_end;

    always_comb begin
        cfg_clamp = (i_cfg_wdata == '0) ? LW'(1) :
                    (i_cfg_wdata > TOP) ? TOP :
                    LW'(i_cfg_wdata);
    end

    assign seg_end = LW'(r_rdata.start) + r_rdata.len;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    always_comb begin
        n_state = r_state; n_count = r_count; n_pool = r_pool;
        n_idx = r_idx; n_k = r_k; n_dst = r_dst; n_gap = r_gap; n_act = r_act;
        n_size = r_size; n_off = r_off; n_cur = r_cur; n_rest = r_rest;
        n_st = r_st; n_res = r_res; n_done = 1'b0;
        mem_we = 1'b0; mem_wa = r_idx; mem_ra = r_idx; mem_wd = r_cur;

        case (r_state)
            S_IDLE: begin
                if (i_cfg_we) begin
                    n_pool  = cfg_clamp;
                    n_count = CW'(1);
                    mem_we  = 1'b1;
                    mem_wa  = '0;
                    mem_wd  = '{start: '0, len: cfg_clamp, free: 1'b1};
                end else if (r_seed) begin
                    // seed entry 0 with the whole pool after reset
                    mem_we  = 1'b1;
                    mem_wa  = '0;
                    mem_wd  = '{start: '0, len: r_pool, free: 1'b1};
                end else if (start) begin
                    n_act  = i_req.action;
                    n_size = LW'(i_req.request_size);
                    n_off  = AW'(i_req.block_offset);
                    n_idx  = '0;
                    n_res  = '0;
                    if (i_req.action == ACT_ALLOC && i_req.request_size == '0) begin
                        n_st = ST_NOFIT; n_state = S_DONE;
                    end else if (i_req.action == ACT_FREE &&
                                 LW'(i_req.block_offset) >= r_pool) begin
                        n_st = ST_BADADDR; n_state = S_DONE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                mem_ra  = r_idx;
                n_state = S_CHK;
            end
            S_CHK: begin
                n_cur = r_rdata;
                if (r_act == ACT_ALLOC) begin
                    if (r_rdata.free && r_size <= r_rdata.len) begin
                        n_res = r_rdata.start;
                        n_st  = ST_OK;
                        if (r_rdata.len != r_size) begin
                            if (r_count >= MAXC) begin
                                n_st = ST_FULL; n_res = '0; n_state = S_DONE;
                            end else begin
                                // mark the head used now; the tail moves above it
                                mem_we  = 1'b1;
                                mem_wa  = r_idx;
                                mem_wd  = '{start: r_rdata.start, len: r_size, free: 1'b0};
                                n_rest = '{start: r_rdata.start + AW'(r_size),
                                           len: r_rdata.len - r_size, free: 1'b1};
                                // open slot r_idx+1 by moving the tail up
                                n_k     = IW'(r_count);
                                n_count = r_count + CW'(1);
                                n_state = (IW'(r_count) == r_idx + IW'(1)) ? S_SPLIT : S_UPRD;
                            end
                        end else begin
                            mem_we  = 1'b1;
                            mem_wa  = r_idx;
                            mem_wd  = '{start: r_rdata.start, len: r_rdata.len, free: 1'b0};
                            n_state = S_DONE;
                        end
                    end else if (CW'(r_idx) + CW'(1) >= r_count) begin
                        n_st = ST_NOFIT; n_state = S_DONE;
                    end else begin
                        n_idx = r_idx + IW'(1); n_state = S_RD;
                    end
                end else begin
                    if (r_rdata.start == r_off) begin
                        n_cur.free = 1'b1;
                        n_st  = ST_OK;
                        n_dst = r_idx;
                        n_gap = 2'd0;
                        if (CW'(r_idx) + CW'(1) < r_count) begin
                            n_state = S_NXRD;
                        end else begin
                            n_state = S_PVRD;
                        end
                    end else if (LW'(r_off) < seg_end ||
                                 CW'(r_idx) + CW'(1) >= r_count) begin
                        n_st = ST_BADADDR; n_state = S_DONE;
                    end else begin
                        n_idx = r_idx + IW'(1); n_state = S_RD;
                    end
                end
            end
            S_UPRD: begin
                mem_ra  = r_k - IW'(1);
                n_state = S_UPWR;
            end
            S_UPWR: begin
                mem_we = 1'b1; mem_wa = r_k; mem_wd = r_rdata;
                n_k = r_k - IW'(1);
                n_state = (r_k - IW'(1) == r_idx + IW'(1)) ? S_SPLIT : S_UPRD;
            end
            S_SPLIT: begin
                mem_we = 1'b1; mem_wa = r_idx + IW'(1); mem_wd = r_rest;
                n_state = S_DONE;
            end
            S_NXRD: begin
                mem_ra  = r_idx + IW'(1);
                n_state = S_NXCK;
            end
            S_NXCK: begin
                // absorb a free next segment
                if (r_rdata.free) begin
                    n_cur.len = r_cur.len + r_rdata.len;
                    n_gap     = 2'd1;
                end
                n_state = S_PVRD;
            end
            S_PVRD: begin
                mem_ra = r_idx - IW'(1);
                n_state = (r_idx == '0) ? S_MRG : S_PVCK;
            end
            S_PVCK: begin
                // a free previous segment absorbs the current one
                if (r_rdata.free) begin
                    n_cur = '{start: r_rdata.start, len: r_rdata.len + r_cur.len,
                              free: 1'b1};
                    n_dst = r_idx - IW'(1);
                    n_gap = r_gap + 2'd1;
                end
                n_state = S_MRG;
            end
            S_MRG: begin
                mem_we  = 1'b1; mem_wa = r_dst; mem_wd = r_cur;
                n_count = r_count - CW'(r_gap);
                n_k     = r_dst + IW'(1);
                if (r_gap == 2'd0 || CW'(r_dst) + CW'(1) >= r_count - CW'(r_gap)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DNRD;
                end
            end
            S_DNRD: begin
                mem_ra  = r_k + IW'(r_gap);
                n_state = S_DNWR;
            end
            S_DNWR: begin
                // close the gap left by the merged entries
                mem_we = 1'b1; mem_wa = r_k; mem_wd = r_rdata;
                n_k = r_k + IW'(1);
                n_state = (CW'(r_k) + CW'(1) >= r_count) ? S_DONE : S_DNRD;
            end
            S_DONE: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= CW'(1);
            r_pool  <= TOP;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pool  <= n_pool;
            r_done  <= n_done;
        end
        r_idx <= n_idx; r_k <= n_k; r_dst <= n_dst; r_gap <= n_gap; r_act <= n_act;
        r_size <= n_size; r_off <= n_off; r_cur <= n_cur; r_rest <= n_rest;
        r_st <= n_st; r_res <= n_res;
    end

    // Hold busy on the first idle cycle after reset while entry 0 is seeded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_seed <= 1'b1;
        else if (r_state == S_IDLE && !i_cfg_we) r_seed <= 1'b0;
    end

    assign busy         = (r_state != S_IDLE) || r_seed;
    assign o_done       = r_done;
    assign o_rsp.status = r_st;
    assign o_rsp.offset = OFFSET_W'(r_res);

    `FFPA_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1,
        (r_count >= CW'(1)) && (r_count <= MAXC), "segment count out of range")
    `FFPA_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done,
        "response strobe held longer than one cycle")
    `FFPA_ASSERT_IMP(a_offset_zero, i_clk, i_rst_n, o_done && (o_rsp.status != ST_OK),
        o_rsp.offset == '0, "offset nonzero on failed request")

endmodule
